### sv/acs_pkg.sv
// Package for the accumulator CPU step block: shared types, codes and constants.
// Depends on nothing; used by every module of the block but acs_ram.
package acs_pkg;

   localparam int MEM_DEPTH_DEFAULT = 4096;
   localparam int WORD_W = 16;
   localparam int ADDR_W = 12;
   localparam int CSR_W = 13;
   localparam logic [12:0] MEM_WORDS_RESET = 13'd4096;
   localparam logic [15:0] PSW_BASE = 16'h0088;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_EXECUTE = 2'd1,
      OP_READ    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   localparam logic [3:0] OPC_LOAD  = 4'h1;
   localparam logic [3:0] OPC_STORE = 4'h2;
   localparam logic [3:0] OPC_CALL  = 4'h3;
   localparam logic [3:0] OPC_CALLNZ = 4'h4;
   localparam logic [3:0] OPC_SWAP  = 4'h5;
   localparam logic [3:0] OPC_ALU   = 4'h6;
   localparam logic [3:0] OPC_HALT  = 4'hF;

   localparam logic [2:0] FN_ZERO = 3'd0;
   localparam logic [2:0] FN_ONES = 3'd1;
   localparam logic [2:0] FN_NOT  = 3'd2;
   localparam logic [2:0] FN_AND  = 3'd3;
   localparam logic [2:0] FN_OR   = 3'd4;
   localparam logic [2:0] FN_XOR  = 3'd5;
   localparam logic [2:0] FN_ADD  = 3'd6;
   localparam logic [2:0] FN_SUB  = 3'd7;

   localparam logic [2:0] SEL_A = 3'd0;
   localparam logic [2:0] SEL_B = 3'd1;
   localparam logic [2:0] SEL_C = 3'd2;
   localparam logic [2:0] SEL_D = 3'd3;
   localparam logic [2:0] SEL_R = 3'd6;
   localparam logic [2:0] SEL_P = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FETCH = 2'd1,
      ST_DATA  = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   // Classified request handed from the front end to the back end.
   typedef struct packed {
      op_type      op;
      logic [11:0] address;
      logic [15:0] data;
      logic        in_range;
   } cmd_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [11:0] prog_counter;
      logic [15:0] accumulator;
      logic [15:0] status_word;
      logic        halted;
   } rsp_type;

endpackage

### sv/accumulator_cpu_step.sv
// Top level of the accumulator CPU step block.
// Write and restart answer from idle; a read goes through done, a step through
// fetch, a load also through data; requests take the single memory port in turn.
// Result register and a two-entry request queue let both sides stall alone.
// Reset is synchronous, active high; it clears pc, registers, halt, queue.
// Memory contents are not cleared by reset.
module accumulator_cpu_step #(
   parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_address,
   input  logic [15:0] req_data,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_read_data,
   output logic [11:0] rsp_prog_counter,
   output logic [15:0] rsp_accumulator,
   output logic [15:0] rsp_status_word,
   output logic        rsp_halted
);
   acs_pkg::cmd_type cmd;
   acs_pkg::rsp_type rsp;
   logic cmd_valid, cmd_take, rsp_valid;

   acs_front #(.MEM_DEPTH(MEM_DEPTH)) u_front (
      .clock(clock), .reset(reset), .req_push(push), .req_full(full),
      .req_operation(req_operation), .req_address(req_address),
      .req_data(req_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
   );

   acs_back #(.MEM_DEPTH(MEM_DEPTH)) u_back (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd), .rsp_valid(rsp_valid), .rsp_taken(pop && rsp_valid), .rsp(rsp)
   );

   assign empty            = !rsp_valid;
   assign rsp_read_data    = rsp.read_data;
   assign rsp_prog_counter = rsp.prog_counter;
   assign rsp_accumulator  = rsp.accumulator;
   assign rsp_status_word  = rsp.status_word;
   assign rsp_halted       = rsp.halted;
endmodule

### sv/acs_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module acs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

### sv/acs_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on acs_pkg.
module acs_front #(
   parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_operation,
   input  logic [11:0]      req_address,
   input  logic [15:0]      req_data,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output acs_pkg::cmd_type cmd
);
   acs_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push_ok, take_ok;
   acs_pkg::cmd_type new_cmd;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign push_ok   = req_push && !req_full;
   assign take_ok   = cmd_take && cmd_valid;
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      new_cmd.op       = acs_pkg::op_type'(req_operation);
      new_cmd.address  = req_address;
      new_cmd.data     = req_data;
      new_cmd.in_range = (32'(req_address) < 32'(MEM_DEPTH));
      cnt_in = cnt_ff + 2'(push_ok) - 2'(take_ok);
      wp_in  = wp_ff ^ push_ok;
      rp_in  = rp_ff ^ take_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push_ok) begin
         q_ff[wp_ff] <= new_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_full |-> cnt_ff == 2'd2)
      else $error("queue count inconsistent");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !take_ok) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count not advanced");
`endif
endmodule

### sv/acs_back.sv
// Back end: executes queued requests against memory and registers.
// Depends on acs_pkg and acs_ram.
module acs_back #(
   parameter int MEM_DEPTH = acs_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [12:0]      csr_wr_data,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  acs_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_taken,
   output acs_pkg::rsp_type rsp
);
   localparam int AW = $clog2(MEM_DEPTH);

   acs_pkg::state_type state_ff, state_in;
   logic [11:0] pc_ff, pc_in;
   logic [15:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [15:0] r_ff, r_in, p_ff, p_in;
   logic        halt_ff, halt_in;
   logic [12:0] words_ff;
   logic [12:0] limit;
   logic [15:0] ir_ff, ir_in;
   logic        fetch_ok_ff, fetch_ok_in;
   logic        rsp_valid_ff, rsp_valid_in;
   acs_pkg::rsp_type rsp_ff, rsp_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [15:0]   ram_wd, ram_rd;
   logic          data_ok_ff, data_ok_in;

   logic          start;
   logic [15:0]   op1, op2, alu_r;
   logic [16:0]   sum;
   logic [16:0]   next_pc;
   logic [15:0]   ir_word;
   logic [15:0]   ld_word;

   acs_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // Output register may hold one result; a new command starts once it is free.
   assign start     = (state_ff == acs_pkg::ST_IDLE) && cmd_valid
                      && (!rsp_valid_ff || rsp_taken);
   assign cmd_take  = start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign limit     = (words_ff == 13'd0 || 32'(words_ff) > 32'(MEM_DEPTH))
                      ? 13'(MEM_DEPTH) : words_ff;
   assign ir_word   = fetch_ok_ff ? ram_rd : 16'h0000;
   assign ld_word   = data_ok_ff ? ram_rd : 16'h0000;

   function automatic logic [15:0] reg_get(input logic [2:0] sel,
      input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
      input logic [15:0] d, input logic [15:0] r, input logic [15:0] p);
      logic [15:0] v;
      unique case (sel)
         acs_pkg::SEL_A: v = a;
         acs_pkg::SEL_B: v = b;
         acs_pkg::SEL_C: v = c;
         acs_pkg::SEL_D: v = d;
         acs_pkg::SEL_R: v = r;
         acs_pkg::SEL_P: v = p;
         default:        v = 16'h0000;
      endcase
      return v;
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         acs_pkg::ST_IDLE: begin
            if (start && cmd.op == acs_pkg::OP_EXECUTE && !halt_ff) begin
               state_in = acs_pkg::ST_FETCH;
            end else if (start && cmd.op == acs_pkg::OP_READ) begin
               state_in = acs_pkg::ST_DONE;
            end
         end
         acs_pkg::ST_FETCH: begin
            state_in = (ir_word[15:12] == acs_pkg::OPC_LOAD) ? acs_pkg::ST_DATA
                       : acs_pkg::ST_IDLE;
         end
         acs_pkg::ST_DATA: state_in = acs_pkg::ST_IDLE;
         acs_pkg::ST_DONE: state_in = acs_pkg::ST_IDLE;
         default:          state_in = acs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pc_in = pc_ff; a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      r_in = r_ff; p_in = p_ff; halt_in = halt_ff;
      ir_in = ir_ff;
      fetch_ok_in = fetch_ok_ff;
      data_ok_in = data_ok_ff;
      ram_we = 1'b0;
      ram_addr = cmd.address[AW-1:0];
      ram_wd = cmd.data;
      rsp_valid_in = rsp_valid_ff && !rsp_taken;
      rsp_in = rsp_ff;
      op1 = reg_get(ir_word[5:3], a_ff, b_ff, c_ff, d_ff, r_ff, p_ff);
      op2 = ir_word[2] ? reg_get({1'b0, ir_word[1:0]}, a_ff, b_ff, c_ff, d_ff,
                                 r_ff, p_ff) : 16'h0000;
      sum = {1'b0, op1} + {1'b0, op2};
      unique case (ir_word[11:9])
         acs_pkg::FN_ZERO: alu_r = 16'h0000;
         acs_pkg::FN_ONES: alu_r = 16'hFFFF;
         acs_pkg::FN_NOT:  alu_r = ~op1;
         acs_pkg::FN_AND:  alu_r = op1 & op2;
         acs_pkg::FN_OR:   alu_r = op1 | op2;
         acs_pkg::FN_XOR:  alu_r = op1 ^ op2;
         acs_pkg::FN_ADD:  alu_r = sum[15:0];
         default:          alu_r = op1 - op2;
      endcase
      next_pc = 17'(pc_ff) + 17'd1;

      unique case (state_ff)
         acs_pkg::ST_IDLE: begin
            if (start) begin
               unique case (cmd.op)
                  acs_pkg::OP_WRITE: begin
                     ram_we = cmd.in_range;
                     rsp_valid_in = 1'b1;
                     rsp_in = '{16'h0000, pc_ff, a_ff, p_ff, halt_ff};
                  end
                  acs_pkg::OP_EXECUTE: begin
                     if (halt_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{16'h0000, pc_ff, a_ff, p_ff, halt_ff};
                     end else begin
                        ram_addr = pc_ff[AW-1:0];
                        fetch_ok_in = (32'(pc_ff) < 32'(MEM_DEPTH));
                     end
                  end
                  acs_pkg::OP_READ: begin
                     fetch_ok_in = cmd.in_range;
                  end
                  default: begin
                     pc_in = 12'd0;
                     halt_in = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_in = '{16'h0000, 12'd0, a_ff, p_ff, 1'b0};
                  end
               endcase
            end
         end
         acs_pkg::ST_FETCH: begin
            ir_in = ir_word;
            ram_addr = ir_word[AW-1:0];
            data_ok_in = (32'(ir_word[11:0]) < 32'(MEM_DEPTH));
            unique case (ir_word[15:12])
               acs_pkg::OPC_STORE: begin
                  ram_we = data_ok_in;
                  ram_wd = a_ff;
               end
               acs_pkg::OPC_CALL: begin
                  r_in = 16'(pc_ff) + 16'd1;
                  next_pc = {5'd0, ir_word[11:0]};
               end
               acs_pkg::OPC_CALLNZ: begin
                  if (a_ff != 16'h0000) begin
                     r_in = 16'(pc_ff) + 16'd1;
                     next_pc = {5'd0, ir_word[11:0]};
                  end
               end
               acs_pkg::OPC_SWAP: begin
                  r_in = 16'(pc_ff) + 16'd1;
                  next_pc = {1'b0, r_ff};
               end
               acs_pkg::OPC_ALU: begin
                  unique case (ir_word[8:6])
                     acs_pkg::SEL_A: a_in = alu_r;
                     acs_pkg::SEL_B: b_in = alu_r;
                     acs_pkg::SEL_C: c_in = alu_r;
                     acs_pkg::SEL_D: d_in = alu_r;
                     acs_pkg::SEL_R: r_in = alu_r;
                     default: ;
                  endcase
                  p_in = acs_pkg::PSW_BASE
                         | {(ir_word[11:9] == acs_pkg::FN_ADD) && sum[16],
                            (ir_word[11:9] == acs_pkg::FN_SUB) && (op1 < op2),
                            op1 < op2, op1 == op2, op1 > op2, 11'd0};
               end
               acs_pkg::OPC_HALT: halt_in = 1'b1;
               default: ;
            endcase
            if (next_pc >= 17'(limit)) begin
               next_pc = 17'd0;
            end
            pc_in = next_pc[11:0];
            if (ir_word[15:12] != acs_pkg::OPC_LOAD) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{ir_word, pc_in, a_in, p_in, halt_in};
            end
         end
         acs_pkg::ST_DATA: begin
            a_in = ld_word;
            rsp_valid_in = 1'b1;
            rsp_in = '{ir_ff, pc_ff, ld_word, p_ff, halt_ff};
         end
         acs_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{ir_word, pc_ff, a_ff, p_ff, halt_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acs_pkg::ST_IDLE;
         pc_ff <= '0; a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0;
         r_ff <= '0; p_ff <= '0; halt_ff <= 1'b0;
         words_ff <= acs_pkg::MEM_WORDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in; a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
         r_ff <= r_in; p_ff <= p_in; halt_ff <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            words_ff <= csr_wr_data;
         end
      end
      ir_ff <= ir_in;
      fetch_ok_ff <= fetch_ok_in;
      data_ok_ff <= data_ok_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_pc_limit: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == acs_pkg::ST_FETCH) |-> 13'(pc_ff) < limit)
      else $error("pc beyond memory size");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == acs_pkg::ST_IDLE)
      else $error("command taken while busy");
   a_halt_hold: assert property (@(posedge clock) disable iff (reset)
      (halt_ff && !(start && cmd.op == acs_pkg::OP_RESTART)) |=> halt_ff)
      else $error("halt cleared without restart");
   a_psw_base: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == acs_pkg::ST_FETCH && ir_word[15:12] == acs_pkg::OPC_ALU)
      |-> p_ff[7:0] == 8'h88)
      else $error("psw rebuilt wrongly");
`endif
endmodule
